// ===== hw/rtl/lppm_pkg.sv =====
`default_nettype none

package lppm_pkg;

  // Register widths and reset values.
  localparam int unsigned HoldW    = 16;
  localparam int unsigned TimeoutW = 24;
  localparam int unsigned FlashW   = 16;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned TimeW    = 32;

  localparam logic [HoldW-1:0]    HoldReset    = 16'd3000;
  localparam logic [TimeoutW-1:0] TimeoutReset = 24'd30000;
  localparam logic [FlashW-1:0]   FlashReset   = 16'd500;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegHoldTime      = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPairTimeout   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegFlashInterval = 2'd2;

  // Operating mode, one-hot.
  typedef enum logic [1:0] {
    MODE_WAITING = 2'b01,
    MODE_PAIRING = 2'b10
  } mode_e;

  typedef struct packed {
    logic [HoldW-1:0]    hold_time;
    logic [TimeoutW-1:0] pair_timeout;
    logic [FlashW-1:0]   flash_interval;
  } cfg_t;

  typedef struct packed {
    mode_e            mode;
    logic             was_down;
    logic [TimeW-1:0] hold_start;
    logic [TimeW-1:0] pair_start;
    logic [TimeW-1:0] next_flash;
    logic             red;
    logic             blue;
  } state_t;

  typedef struct packed {
    logic mode;
    logic red_led;
    logic blue_led;
    logic started;
    logic cancelled;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lppm_cfg.sv =====
`default_nettype none

module lppm_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [lppm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [lppm_pkg::CfgDataW-1:0] cfg_data_i,
  output lppm_pkg::cfg_t                     cfg_o
);

  lppm_pkg::cfg_t cfg_q;

  // Register file; writes to an unused index are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_time      <= lppm_pkg::HoldReset;
      cfg_q.pair_timeout   <= lppm_pkg::TimeoutReset;
      cfg_q.flash_interval <= lppm_pkg::FlashReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lppm_pkg::RegHoldTime: begin
          cfg_q.hold_time <= cfg_data_i[lppm_pkg::HoldW-1:0];
        end
        lppm_pkg::RegPairTimeout: begin
          cfg_q.pair_timeout <= cfg_data_i[lppm_pkg::TimeoutW-1:0];
        end
        lppm_pkg::RegFlashInterval: begin
          cfg_q.flash_interval <= cfg_data_i[lppm_pkg::FlashW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== hw/rtl/lppm_step.sv =====
`default_nettype none

module lppm_step (
  input  wire lppm_pkg::state_t           cur_i,
  input  wire lppm_pkg::cfg_t             cfg_i,
  input  wire logic [lppm_pkg::TimeW-1:0] now_ms_i,
  input  wire logic                       button_down_i,
  output lppm_pkg::state_t                nxt_o,
  output lppm_pkg::result_t               res_o
);

  logic                       edge_seen;
  logic [lppm_pkg::TimeW-1:0] hold_deadline;
  logic [lppm_pkg::TimeW-1:0] pair_limit;
  logic                       long_hold;
  logic                       started;
  logic                       cancelled;

  // Deadlines wrap modulo 2^32.
  assign hold_deadline = cur_i.hold_start
                       + {{(lppm_pkg::TimeW-lppm_pkg::HoldW){1'b0}}, cfg_i.hold_time};
  assign pair_limit    = cur_i.pair_start
                       + {{(lppm_pkg::TimeW-lppm_pkg::TimeoutW){1'b0}}, cfg_i.pair_timeout};

  // Hold check uses the state before this item's edge tracking; it only
  // matters when no edge was seen, where that state is unchanged.
  assign edge_seen = cur_i.was_down != button_down_i;
  assign long_hold = cur_i.was_down && button_down_i && (now_ms_i > hold_deadline);

  always_comb begin
    nxt_o     = cur_i;
    started   = 1'b0;
    cancelled = 1'b0;

    // Edge tracking is common to both modes.
    if (edge_seen) begin
      nxt_o.was_down = button_down_i;
      if (button_down_i) begin
        nxt_o.hold_start = now_ms_i;
      end
    end

    case (cur_i.mode)
      lppm_pkg::MODE_WAITING: begin
        if (!edge_seen && long_hold) begin
          nxt_o.mode       = lppm_pkg::MODE_PAIRING;
          nxt_o.red        = 1'b0;
          nxt_o.pair_start = now_ms_i;
          nxt_o.hold_start = now_ms_i;
          started          = 1'b1;
        end
      end
      lppm_pkg::MODE_PAIRING: begin
        // Blue LED flashing runs ahead of the cancel checks.
        if (now_ms_i >= cur_i.next_flash) begin
          nxt_o.blue       = !cur_i.blue;
          nxt_o.next_flash = now_ms_i
                           + {{(lppm_pkg::TimeW-lppm_pkg::FlashW){1'b0}}, cfg_i.flash_interval};
        end
        if (!edge_seen && (long_hold || (now_ms_i > pair_limit))) begin
          nxt_o.mode       = lppm_pkg::MODE_WAITING;
          nxt_o.red        = 1'b1;
          nxt_o.blue       = 1'b0;
          nxt_o.hold_start = now_ms_i;
          cancelled        = 1'b1;
        end
      end
      default: begin
        nxt_o.mode = lppm_pkg::MODE_WAITING;
      end
    endcase
  end

  // Result fields reflect the state after this item.
  assign res_o.mode      = nxt_o.mode == lppm_pkg::MODE_PAIRING;
  assign res_o.red_led   = nxt_o.red;
  assign res_o.blue_led  = nxt_o.blue;
  assign res_o.started   = started;
  assign res_o.cancelled = cancelled;

endmodule

`default_nettype wire

// ===== hw/rtl/long_press_pairing_mode_controller.sv =====
`default_nettype none

// Long-press pairing controller. Each input item is one pass of a control
// loop (millisecond time and button level) and yields exactly one result
// item with the mode, both LED levels and the started/cancelled pulses.
// An item is captured in an input register, evaluated combinationally
// against the stored state and placed in an output register, so one item
// is taken every clock while the output is not stalled. While a finished
// result waits to be taken, the input register can still take one more
// item. Configuration registers are written through cfg_we_i, cfg_idx_i
// and cfg_data_i and must only be changed while no item is in flight.
module long_press_pairing_mode_controller (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic [lppm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [lppm_pkg::CfgDataW-1:0] cfg_data_i,
  // Input channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [lppm_pkg::TimeW-1:0]    now_ms_i,
  input  wire logic                          button_down_i,
  // Output channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               mode_o,
  output logic                               red_led_o,
  output logic                               blue_led_o,
  output logic                               pairing_started_o,
  output logic                               pairing_cancelled_o
);

  lppm_pkg::cfg_t    cfg;
  lppm_pkg::state_t  state_q;
  lppm_pkg::state_t  state_d;
  lppm_pkg::result_t res_d;
  lppm_pkg::result_t res_q;

  logic                       in_valid_q;
  logic [lppm_pkg::TimeW-1:0] now_q;
  logic                       down_q;
  logic                       out_valid_q;
  logic                       advance;
  logic                       in_take;

  lppm_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  lppm_step u_step (
    .cur_i         (state_q),
    .cfg_i         (cfg),
    .now_ms_i      (now_q),
    .button_down_i (down_q),
    .nxt_o         (state_d),
    .res_o         (res_d)
  );

  // The output register frees up when empty or when its item is taken.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  // Input register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  // Input payload.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      now_q  <= now_ms_i;
      down_q <= button_down_i;
    end
  end

  // Controller state updates once per evaluated item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode       <= lppm_pkg::MODE_WAITING;
      state_q.was_down   <= 1'b0;
      state_q.hold_start <= '0;
      state_q.pair_start <= '0;
      state_q.next_flash <= '0;
      state_q.red        <= 1'b0;
      state_q.blue       <= 1'b0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Output register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign mode_o              = res_q.mode;
  assign red_led_o           = res_q.red_led;
  assign blue_led_o          = res_q.blue_led;
  assign pairing_started_o   = res_q.started;
  assign pairing_cancelled_o = res_q.cancelled;

endmodule

`default_nettype wire
